// ===== rtl/itp_pkg.sv =====
// Shared constants, result codes and character helpers for the infix to postfix converter.
// No dependencies; used by itp_stack_ram and infix_to_postfix_converter.
`default_nettype none

package itp_pkg;

   localparam int DEFAULT_STACK_DEPTH = 32;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;
   localparam int ERR_W  = 2;
   localparam int PREC_W = 2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd2;

   // request actions
   localparam logic ACT_CHAR = 1'b0;
   localparam logic ACT_END  = 1'b1;

   // characters of interest
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7F;
   localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7A;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] out_char;
      logic [ERR_W-1:0]  error_code;
   } result_type;

   function automatic logic [PREC_W-1:0] prec_of(input logic [CHAR_W-1:0] c);
      logic [PREC_W-1:0] p;
      begin
         if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
         end else if (c == CH_STAR || c == CH_SLASH) begin
            p = 2'd2;
         end else if (c == CH_CARET) begin
            p = 2'd3;
         end else begin
            p = 2'd0;
         end
         return p;
      end
   endfunction

   function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
      return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
             (c >= CH_LA && c <= CH_LZ);
   endfunction

   function automatic logic is_skip(input logic [CHAR_W-1:0] c);
      return (c <= CH_SPACE) || (c == CH_DEL);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/itp_stack_ram.sv =====
// Operator stack storage: one write port, one registered read port.
// Depends on itp_pkg for the character width.
`default_nettype none

module itp_stack_ram #(
   parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH,
   parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [itp_pkg::CHAR_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output      logic [itp_pkg::CHAR_W-1:0] rd_data
);
   import itp_pkg::*;

   logic [CHAR_W-1:0] stack_mem [STACK_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/infix_to_postfix_converter.sv =====
// Infix to postfix converter: operator-stack sequencer with pending and output result registers.
// Depends on itp_pkg and itp_stack_ram.
//
//   channel  dir  payload                                   handshake
//   req_     in   tuser=action, tdata=in_char               tvalid/tready
//   rsp_     out  tuser=kind, tdata=error_code:out_char,    tvalid/tready
//                 tlast=last
//
// A letter or digit is emitted at once, a skipped character is dropped and an
// opening parenthesis is pushed. Every pop first addresses the stack memory,
// then inspects the registered top entry; an end or a ')' pops until the stack
// is empty or the matching '(' is found, an operator until a lower-precedence
// entry or an empty stack stops it, and any result may wait on rsp_tready.
// req_tready is high only while the sequencer is idle; a finished result
// may still wait in the output register then. Reset is synchronous and
// empties the stack; the stack memory itself is not cleared.
`default_nettype none

module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_char
   input  wire logic [0:0]  req_tuser,   // [0] action
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [7:0] out_char, [9:8] error_code, [15:10] zero
   output      logic [1:0]  rsp_tuser,   // [1:0] kind
   output      logic        rsp_tlast
);
   import itp_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_CHK,
      S_PUSH,
      S_FIN
   } state_type;

   typedef enum logic [1:0] {
      MODE_FLUSH,
      MODE_CLOSE,
      MODE_OP
   } mode_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              pend_valid_ff, pend_valid_in;
   result_type        pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_xfer;
   logic              out_free;
   logic              emit_go;
   logic              emit;
   result_type        emit_res;
   logic              stack_full;
   logic [CNT_W-1:0]  cnt_dec;

   logic              wr_en;
   logic              rd_en;
   logic [CHAR_W-1:0] top_char;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_go    = !pend_valid_ff || out_free;
   assign stack_full = (count_ff == CNT_W'(STACK_DEPTH));
   assign cnt_dec    = count_ff - CNT_W'(1);

   itp_stack_ram #(
      .STACK_DEPTH (STACK_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (char_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_dec[ADDR_W-1:0]),
      .rd_data (top_char)
   );

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      char_in       = char_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      emit          = 1'b0;
      emit_res      = '{kind: KIND_CHAR, out_char: '0, error_code: ERR_NONE};

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               char_in = req_tdata;
               if (req_tuser[0] == ACT_END) begin
                  mode_in  = MODE_FLUSH;
                  state_in = S_RD;
               end else if (is_alnum(req_tdata)) begin
                  emit     = 1'b1;
                  emit_res = '{kind: KIND_CHAR, out_char: req_tdata, error_code: ERR_NONE};
                  state_in = S_FIN;
               end else if (is_skip(req_tdata)) begin
                  state_in = S_IDLE;
               end else if (req_tdata == CH_RPAREN) begin
                  mode_in  = MODE_CLOSE;
                  state_in = S_RD;
               end else if (req_tdata == CH_LPAREN) begin
                  state_in = S_PUSH;
               end else begin
                  mode_in  = MODE_OP;
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (count_ff == '0) begin
               unique case (mode_ff)
                  MODE_FLUSH: begin
                     if (emit_go) begin
                        emit     = 1'b1;
                        emit_res = '{kind: KIND_END, out_char: '0, error_code: ERR_NONE};
                        state_in = S_FIN;
                     end
                  end
                  MODE_CLOSE: begin
                     if (emit_go) begin
                        emit     = 1'b1;
                        emit_res = '{kind: KIND_ERROR, out_char: '0,
                                     error_code: ERR_UNMATCHED};
                        state_in = S_FIN;
                     end
                  end
                  default: begin
                     state_in = S_PUSH;
                  end
               endcase
            end else begin
               rd_en    = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            unique case (mode_ff)
               MODE_FLUSH: begin
                  if (emit_go) begin
                     emit     = 1'b1;
                     emit_res = '{kind: KIND_CHAR, out_char: top_char, error_code: ERR_NONE};
                     count_in = cnt_dec;
                     state_in = S_RD;
                  end
               end
               MODE_CLOSE: begin
                  if (top_char == CH_LPAREN) begin
                     // drop the matching opening parenthesis
                     count_in = cnt_dec;
                     state_in = S_FIN;
                  end else if (emit_go) begin
                     emit     = 1'b1;
                     emit_res = '{kind: KIND_CHAR, out_char: top_char, error_code: ERR_NONE};
                     count_in = cnt_dec;
                     state_in = S_RD;
                  end
               end
               default: begin
                  if (prec_of(top_char) < prec_of(char_ff)) begin
                     state_in = S_PUSH;
                  end else if (emit_go) begin
                     emit     = 1'b1;
                     emit_res = '{kind: KIND_CHAR, out_char: top_char, error_code: ERR_NONE};
                     count_in = cnt_dec;
                     state_in = S_RD;
                  end
               end
            endcase
         end
         S_PUSH: begin
            if (stack_full) begin
               if (emit_go) begin
                  emit     = 1'b1;
                  emit_res = '{kind: KIND_ERROR, out_char: '0, error_code: ERR_OVERFLOW};
                  count_in = '0;
                  state_in = S_FIN;
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // release the held result as the final one of this item
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_in        = pend_ff;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a new result pushes the held one out as not last
      if (emit) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         pend_in       = emit_res;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= MODE_FLUSH;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      char_ff     <= char_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {6'd0, rsp_ff.error_code, rsp_ff.out_char};
   assign rsp_tlast  = rsp_last_ff;

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("result still held while taking a new request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_ERROR) |-> (rsp_last_ff && rsp_ff.out_char == '0))
      else $error("error result not final or carries a character");

   a_overflow_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH && stack_full && emit_go) |=> (count_ff == '0))
      else $error("stack not cleared after overflow");

endmodule

`default_nettype wire
